[design/owrs_pkg.sv]
// Shared types and constants for the 1-Wire ROM search engine.
package owrs_pkg;

   // ROM geometry
   localparam int ROM_BITS = 64;
   localparam int BIT_NUM_W = 7;
   localparam logic [BIT_NUM_W-1:0] LAST_BIT = BIT_NUM_W'(ROM_BITS);

   // Search command bytes
   localparam logic [7:0] CMD_SEARCH = 8'hF0;
   localparam logic [7:0] CMD_ALARM_SEARCH = 8'hEC;

   // Opcodes
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_TARGET = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;
   localparam logic [1:0] OP_TRIPLET = 2'd3;

   // Status codes
   localparam logic [2:0] ST_ACK = 3'd0;
   localparam logic [2:0] ST_SEND_DIR = 3'd1;
   localparam logic [2:0] ST_FOUND = 3'd2;
   localparam logic [2:0] ST_NO_PRESENCE = 3'd3;
   localparam logic [2:0] ST_FINISHED = 3'd4;
   localparam logic [2:0] ST_BUS_ERROR = 3'd5;

   // One request transaction
   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] family_byte;
      logic       presence;
      logic       id_bit;
      logic       comp_bit;
      logic       taken_dir;
   } request_type;

   // One response transaction
   typedef struct packed {
      logic [2:0]           status;
      logic                 request_direction;
      logic [BIT_NUM_W-1:0] bit_number;
      logic [7:0]           command_code;
      logic [ROM_BITS-1:0]  rom_id;
      logic                 last_device;
   } result_type;

   // Search progress seen by the top level
   typedef struct packed {
      logic                 pass_active;
      logic                 search_done;
      logic [BIT_NUM_W-1:0] current_bit;
   } progress_type;

endpackage

[design/owrs_core.sv]
// Search state registers and the per-transaction update logic.
module owrs_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  owrs_pkg::request_type req,
   input  logic                  kind_write,
   input  logic                  kind_data,
   output owrs_pkg::result_type  result,
   output owrs_pkg::progress_type progress
);
   import owrs_pkg::*;

   logic [ROM_BITS-1:0]  rom_ff, rom_in;
   logic [BIT_NUM_W-1:0] last_disc_ff, last_disc_in;
   logic [BIT_NUM_W-1:0] zero_branch_ff, zero_branch_in;
   logic [BIT_NUM_W-1:0] cur_bit_ff, cur_bit_in;
   logic                 done_ff, done_in;
   logic                 active_ff, active_in;
   logic                 kind_ff;
   logic [BIT_NUM_W-1:0] next_bit;
   logic [5:0]           cur_idx;
   logic [5:0]           next_idx;
   logic                 pass_dir;
   logic                 step_dir;

   assign next_bit = cur_bit_ff + BIT_NUM_W'(1);
   assign cur_idx  = 6'(cur_bit_ff - BIT_NUM_W'(1));
   assign next_idx = cur_bit_ff[5:0];

   // Direction for the first bit of a pass.
   always_comb begin
      if (last_disc_ff > BIT_NUM_W'(1)) begin
         pass_dir = rom_ff[0];
      end else begin
         pass_dir = (last_disc_ff == BIT_NUM_W'(1));
      end
   end

   // Direction for the bit after the current one.
   always_comb begin
      if (next_bit < last_disc_ff) begin
         step_dir = rom_ff[next_idx];
      end else begin
         step_dir = (next_bit == last_disc_ff);
      end
   end

   // Next state and response for one request transaction.
   always_comb begin
      rom_in         = rom_ff;
      last_disc_in   = last_disc_ff;
      zero_branch_in = zero_branch_ff;
      cur_bit_in     = cur_bit_ff;
      done_in        = done_ff;
      active_in      = active_ff;
      result         = '0;
      result.status  = ST_ACK;
      case (req.opcode)
         OP_CLEAR: begin
            rom_in         = '0;
            last_disc_in   = '0;
            zero_branch_in = '0;
            done_in        = 1'b0;
            cur_bit_in     = '0;
            active_in      = 1'b0;
         end
         OP_TARGET: begin
            rom_in         = {{(ROM_BITS-8){1'b0}}, req.family_byte};
            last_disc_in   = LAST_BIT;
            zero_branch_in = '0;
            done_in        = 1'b0;
            cur_bit_in     = '0;
            active_in      = 1'b0;
         end
         OP_START: begin
            if (done_ff) begin
               result.status = ST_FINISHED;
            end else if (!req.presence) begin
               result.status = ST_NO_PRESENCE;
               active_in     = 1'b0;
               cur_bit_in    = '0;
            end else begin
               active_in      = 1'b1;
               cur_bit_in     = BIT_NUM_W'(1);
               zero_branch_in = '0;
               result.status            = ST_SEND_DIR;
               result.request_direction = pass_dir;
               result.bit_number        = BIT_NUM_W'(1);
               result.command_code      = kind_ff ? CMD_ALARM_SEARCH : CMD_SEARCH;
            end
         end
         OP_TRIPLET: begin
            if (active_ff && cur_bit_ff >= BIT_NUM_W'(1) && cur_bit_ff <= LAST_BIT) begin
               if (req.id_bit && req.comp_bit) begin
                  active_in     = 1'b0;
                  cur_bit_in    = '0;
                  result.status = ST_BUS_ERROR;
               end else begin
                  if (!req.id_bit && !req.comp_bit && !req.taken_dir) begin
                     zero_branch_in = cur_bit_ff;
                  end
                  rom_in[cur_idx] = req.taken_dir;
                  if (cur_bit_ff == LAST_BIT) begin
                     last_disc_in = zero_branch_in;
                     done_in      = done_ff || (zero_branch_in == '0);
                     active_in    = 1'b0;
                     cur_bit_in   = '0;
                     result.status      = ST_FOUND;
                     result.rom_id      = rom_in;
                     result.last_device = done_in;
                  end else begin
                     cur_bit_in = next_bit;
                     result.status            = ST_SEND_DIR;
                     result.request_direction = step_dir;
                     result.bit_number        = next_bit;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rom_ff         <= '0;
         last_disc_ff   <= '0;
         zero_branch_ff <= '0;
         cur_bit_ff     <= '0;
         done_ff        <= 1'b0;
         active_ff      <= 1'b0;
         kind_ff        <= 1'b0;
      end else begin
         if (step) begin
            rom_ff         <= rom_in;
            last_disc_ff   <= last_disc_in;
            zero_branch_ff <= zero_branch_in;
            cur_bit_ff     <= cur_bit_in;
            done_ff        <= done_in;
            active_ff      <= active_in;
         end
         if (kind_write) begin
            kind_ff <= kind_data;
         end
      end
   end

   assign progress.pass_active = active_ff;
   assign progress.search_done = done_ff;
   assign progress.current_bit = cur_bit_ff;

endmodule

[design/one_wire_rom_search.sv]
// Top level of the 1-Wire ROM search engine: handshakes and response buffering.
// An accepted request's response is registered in the response register, or in the skid entry while that is held.
// One request transaction per cycle while req_stall is low; the search state registers update on each accepted request.
// A response register plus one skid entry let a request be taken while a response waits.
// Reset is synchronous and active high; it clears the search state and search_kind.
module one_wire_rom_search (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_opcode,
   input  logic [7:0]                      req_family_byte,
   input  logic                            req_presence,
   input  logic                            req_id_bit,
   input  logic                            req_comp_bit,
   input  logic                            req_taken_dir,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_status,
   output logic                            rsp_request_direction,
   output logic [owrs_pkg::BIT_NUM_W-1:0]  rsp_bit_number,
   output logic [7:0]                      rsp_command_code,
   output logic [owrs_pkg::ROM_BITS-1:0]   rsp_rom_id,
   output logic                            rsp_last_device,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_data
);
   import owrs_pkg::*;

   request_type  req;
   result_type   result;
   progress_type progress;
   logic         accept;
   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   result_type   out_ff, out_in;
   result_type   skid_ff, skid_in;
   logic         out_free;

   assign req.opcode      = req_opcode;
   assign req.family_byte = req_family_byte;
   assign req.presence    = req_presence;
   assign req.id_bit      = req_id_bit;
   assign req.comp_bit    = req_comp_bit;
   assign req.taken_dir   = req_taken_dir;

   // The register write is always taken at once.
   assign csr_ready = 1'b1;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;

   owrs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .req        (req),
      .kind_write (csr_valid && csr_ready),
      .kind_data  (csr_data),
      .result     (result),
      .progress   (progress)
   );

   // Response register with one skid entry behind it.
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_status            = out_ff.status;
   assign rsp_request_direction = out_ff.request_direction;
   assign rsp_bit_number        = out_ff.bit_number;
   assign rsp_command_code      = out_ff.command_code;
   assign rsp_rom_id            = out_ff.rom_id;
   assign rsp_last_device       = out_ff.last_device;

   // The skid entry only fills behind a held response.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a response while the output register is empty");

   // An active pass always points at a ROM bit in range.
   assert property (@(posedge clock) disable iff (reset)
      progress.pass_active |->
         (progress.current_bit >= BIT_NUM_W'(1) && progress.current_bit <= LAST_BIT))
      else $error("active pass with bit position out of range");

   // A response that is not a direction request carries no bit position.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_SEND_DIR) |-> (rsp_bit_number == '0))
      else $error("bit position set on a response that is not a direction request");

   // A finished search does not start a pass.
   assert property (@(posedge clock) disable iff (reset)
      (accept && progress.search_done && req_opcode == OP_START) |=>
         !progress.pass_active)
      else $error("pass started after the search finished");

endmodule

[verif/one_wire_rom_search_tb.sv]
// Self-checking testbench for the 1-Wire ROM search engine with a simulated device bus.
`timescale 1ns / 1ps

module one_wire_rom_search_tb;
   import owrs_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_DEVICES = 8;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_opcode;
   logic [7:0]           req_family_byte;
   logic                 req_presence;
   logic                 req_id_bit;
   logic                 req_comp_bit;
   logic                 req_taken_dir;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [2:0]           rsp_status;
   logic                 rsp_request_direction;
   logic [BIT_NUM_W-1:0] rsp_bit_number;
   logic [7:0]           rsp_command_code;
   logic [ROM_BITS-1:0]  rsp_rom_id;
   logic                 rsp_last_device;
   logic                 csr_valid;
   logic                 csr_ready;
   logic                 csr_data;

   // Search state mirrored by the predictor.
   logic [ROM_BITS-1:0]  rom_state;
   logic [BIT_NUM_W-1:0] last_disc;
   logic [BIT_NUM_W-1:0] zero_branch;
   logic                 search_over;
   logic [BIT_NUM_W-1:0] cur_bit;
   logic                 pass_open;
   logic                 kind_setting;

   // Responses still owed by the block, oldest first.
   result_type           pending_results[$];
   result_type           last_prediction;

   // Devices present on the simulated bus.
   logic [ROM_BITS-1:0]  bus_roms[$];

   bit                   running;
   bit                   full_rate;
   int                   error_count;
   int                   idle_cycles;
   int                   requests_sent;
   int                   responses_checked;
   int                   kind_writes;
   int                   status_seen[0:7];

   one_wire_rom_search i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_opcode            (req_opcode),
      .req_family_byte       (req_family_byte),
      .req_presence          (req_presence),
      .req_id_bit            (req_id_bit),
      .req_comp_bit          (req_comp_bit),
      .req_taken_dir         (req_taken_dir),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_request_direction (rsp_request_direction),
      .rsp_bit_number        (rsp_bit_number),
      .rsp_command_code      (rsp_command_code),
      .rsp_rom_id            (rsp_rom_id),
      .rsp_last_device       (rsp_last_device),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_data              (csr_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Direction the search asks for at ROM bit position pos (1..64).
   function automatic logic branch_direction(input logic [BIT_NUM_W-1:0] pos);
      if (pos < last_disc) begin
         return rom_state[6'(pos - 7'd1)];
      end
      return (pos == last_disc);
   endfunction

   // Advances the mirrored search by one request and returns the response it owes.
   function automatic result_type search_step(input request_type rq);
      result_type r;
      r = '0;
      r.status = ST_ACK;
      case (rq.opcode)
         OP_CLEAR: begin
            rom_state = '0;
            last_disc = '0;
            zero_branch = '0;
            search_over = 1'b0;
            cur_bit = '0;
            pass_open = 1'b0;
         end
         OP_TARGET: begin
            rom_state = {56'd0, rq.family_byte};
            last_disc = LAST_BIT;
            zero_branch = '0;
            search_over = 1'b0;
            cur_bit = '0;
            pass_open = 1'b0;
         end
         OP_START: begin
            if (search_over) begin
               r.status = ST_FINISHED;
            end else if (!rq.presence) begin
               r.status = ST_NO_PRESENCE;
               pass_open = 1'b0;
               cur_bit = '0;
            end else begin
               pass_open = 1'b1;
               cur_bit = 7'd1;
               zero_branch = '0;
               r.status = ST_SEND_DIR;
               r.request_direction = branch_direction(cur_bit);
               r.bit_number = cur_bit;
               r.command_code = kind_setting ? CMD_ALARM_SEARCH : CMD_SEARCH;
            end
         end
         default: begin
            // Triplets outside a pass are acknowledged and dropped.
            if (pass_open && cur_bit >= 7'd1 && cur_bit <= LAST_BIT) begin
               if (rq.id_bit && rq.comp_bit) begin
                  pass_open = 1'b0;
                  cur_bit = '0;
                  r.status = ST_BUS_ERROR;
               end else begin
                  if (!rq.id_bit && !rq.comp_bit && !rq.taken_dir) begin
                     zero_branch = cur_bit;
                  end
                  rom_state[6'(cur_bit - 7'd1)] = rq.taken_dir;
                  if (cur_bit == LAST_BIT) begin
                     last_disc = zero_branch;
                     if (zero_branch == '0) begin
                        search_over = 1'b1;
                     end
                     pass_open = 1'b0;
                     cur_bit = '0;
                     r.status = ST_FOUND;
                     r.rom_id = rom_state;
                     r.last_device = search_over;
                  end else begin
                     cur_bit = cur_bit + 7'd1;
                     r.status = ST_SEND_DIR;
                     r.request_direction = branch_direction(cur_bit);
                     r.bit_number = cur_bit;
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (full_rate) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // Drives one request transaction and records its predicted response once accepted.
   task automatic send_request(input logic [1:0] op, input logic [7:0] fam, input logic pres,
                               input logic idb, input logic cmp, input logic dir);
      request_type rq;
      int gap;
      rq.opcode = op;
      rq.family_byte = fam;
      rq.presence = pres;
      rq.id_bit = idb;
      rq.comp_bit = cmp;
      rq.taken_dir = dir;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= rq.opcode;
      req_family_byte <= rq.family_byte;
      req_presence <= rq.presence;
      req_id_bit <= rq.id_bit;
      req_comp_bit <= rq.comp_bit;
      req_taken_dir <= rq.taken_dir;
      do @(posedge clock); while (req_stall !== 1'b0);
      last_prediction = search_step(rq);
      pending_results.push_back(last_prediction);
      requests_sent++;
   endtask

   // Stops sending and waits until every owed response has come back.
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_search_kind(input logic kind);
      quiesce();
      repeat (2) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= kind;
      do @(posedge clock); while (csr_ready !== 1'b1);
      kind_setting = kind;
      kind_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One search pass over the simulated bus, answering each bit as the wired-AND would.
   task automatic run_search_pass();
      bit on_branch[0:MAX_DEVICES-1];
      logic all_one;
      logic all_zero;
      logic took;
      int pos;
      send_request(OP_START, 8'($urandom), 1'b1, 1'($urandom), 1'($urandom), 1'($urandom));
      for (int i = 0; i < MAX_DEVICES; i++) begin
         on_branch[i] = (i < bus_roms.size());
      end
      while (last_prediction.status == ST_SEND_DIR) begin
         pos = int'(last_prediction.bit_number) - 1;
         all_one = 1'b1;
         all_zero = 1'b1;
         for (int i = 0; i < bus_roms.size(); i++) begin
            if (on_branch[i]) begin
               if (bus_roms[i][pos]) all_zero = 1'b0;
               else all_one = 1'b0;
            end
         end
         // Discrepancy follows the request, an empty branch is random; else the bus decides.
         if (all_one == all_zero) begin
            took = all_one ? 1'($urandom) : last_prediction.request_direction;
         end else begin
            took = all_one;
         end
         send_request(OP_TRIPLET, 8'($urandom), 1'($urandom), all_one, all_zero, took);
         for (int i = 0; i < bus_roms.size(); i++) begin
            on_branch[i] = on_branch[i] && (bus_roms[i][pos] == took);
         end
      end
   endtask

   // Fills the bus with devices; some share a family byte or differ from the first in one bit.
   task automatic populate_bus(input int count, input logic [7:0] family);
      logic [ROM_BITS-1:0] rom;
      bus_roms.delete();
      for (int i = 0; i < count; i++) begin
         rom = {32'($urandom), 32'($urandom)};
         if ($urandom_range(0, 1) == 1) rom[7:0] = family;
         if (i > 0 && $urandom_range(0, 2) == 0) begin
            rom = bus_roms[0] ^ (64'd1 << $urandom_range(0, 63));
         end
         bus_roms.push_back(rom);
      end
   endtask

   task automatic enumerate_bus(input int count, input int max_passes);
      populate_bus(count, 8'($urandom));
      send_request(OP_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                   1'($urandom));
      for (int p = 0; p < max_passes; p++) begin
         run_search_pass();
         if (last_prediction.status == ST_FINISHED) break;
      end
   endtask

   task automatic test_special_cases();
      send_request(OP_TRIPLET, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
      send_request(OP_START,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(OP_START,   8'hFF, 1'b1, 1'b0, 1'b0, 1'b0);
      send_request(OP_TRIPLET, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(OP_TRIPLET, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1);
      // A new pass started while one runs replaces it.
      send_request(OP_START,   8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
      send_request(OP_TRIPLET, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0);
      send_request(OP_TRIPLET, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
      send_request(OP_START,   8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
      send_request(OP_TRIPLET, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
      // Clear and target both cut a running pass short.
      send_request(OP_CLEAR,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(OP_TRIPLET, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
      send_request(OP_TARGET,  8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(OP_START,   8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
      send_request(OP_TRIPLET, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
      send_request(OP_TARGET,  8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
      send_request(OP_START,   8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
      send_request(OP_TRIPLET, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
      send_request(OP_TARGET,  8'h5A, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(OP_START,   8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
      // A start without presence ends the running pass.
      send_request(OP_START,   8'hA5, 1'b0, 1'b0, 1'b0, 1'b0);
      send_request(OP_TRIPLET, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
      send_request(OP_CLEAR,   8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
   endtask

   task automatic test_full_enumeration();
      enumerate_bus(3, 5);
   endtask

   task automatic test_alarm_search();
      write_search_kind(1'b1);
      enumerate_bus(2, 4);
      write_search_kind(1'b0);
   endtask

   task automatic test_family_target();
      logic [7:0] family;
      family = 8'($urandom);
      populate_bus(4, family);
      send_request(OP_TARGET, family, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      run_search_pass();
      run_search_pass();
   endtask

   task automatic test_empty_bus();
      bus_roms.delete();
      send_request(OP_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
      run_search_pass();
   endtask

   // Random requests, including broken passes, with one full drain halfway.
   task automatic test_request_noise(input int count);
      int roll;
      logic [1:0] op;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 55) op = OP_TRIPLET;
         else if (roll < 75) op = OP_START;
         else if (roll < 87) op = OP_TARGET;
         else op = OP_CLEAR;
         send_request(op, 8'($urandom), 1'($urandom_range(0, 3) != 0), 1'($urandom),
                      1'($urandom), 1'($urandom));
         if (n == count / 2) quiesce();
      end
   endtask

   task automatic test_full_rate();
      full_rate = 1'b1;
      enumerate_bus(2, 4);
      full_rate = 1'b0;
   endtask

   // Response checker: each accepted response against the oldest prediction.
   task automatic check_response();
      result_type want;
      if (pending_results.size() == 0) begin
         report_error($sformatf("response with status %0d and no request outstanding",
                                rsp_status));
         return;
      end
      want = pending_results.pop_front();
      responses_checked++;
      status_seen[want.status]++;
      if (rsp_status !== want.status)
         report_error($sformatf("status %0d, predicted %0d", rsp_status, want.status));
      if (rsp_request_direction !== want.request_direction)
         report_error($sformatf("request_direction %0b, predicted %0b",
                                rsp_request_direction, want.request_direction));
      if (rsp_bit_number !== want.bit_number)
         report_error($sformatf("bit_number %0d, predicted %0d", rsp_bit_number,
                                want.bit_number));
      if (rsp_command_code !== want.command_code)
         report_error($sformatf("command_code %h, predicted %h", rsp_command_code,
                                want.command_code));
      if (rsp_rom_id !== want.rom_id)
         report_error($sformatf("rom_id %h, predicted %h", rsp_rom_id, want.rom_id));
      if (rsp_last_device !== want.last_device)
         report_error($sformatf("last_device %0b, predicted %0b", rsp_last_device,
                                want.last_device));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         check_response();
      end
   end

   // Receiver back-pressure: mostly short stalls, some long, with open stretches.
   initial begin : response_backpressure
      int roll;
      int span;
      forever begin
         roll = $urandom_range(0, 99);
         if (full_rate || roll < 50) begin
            rsp_stall <= 1'b0;
            span = $urandom_range(1, 10);
         end else if (roll < 90) begin
            rsp_stall <= 1'b1;
            span = $urandom_range(1, 3);
         end else begin
            rsp_stall <= 1'b1;
            span = $urandom_range(10, 30);
         end
         repeat (span) @(negedge clock);
      end
   end

   // Watchdog on cycles with no transaction on any channel.
   always @(posedge clock) begin
      if (running) begin
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
             (csr_valid && csr_ready === 1'b1)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("one_wire_rom_search regression: fail");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= OP_CLEAR;
      req_family_byte <= '0;
      req_presence <= 1'b0;
      req_id_bit <= 1'b0;
      req_comp_bit <= 1'b0;
      req_taken_dir <= 1'b0;
      csr_valid <= 1'b0;
      csr_data <= 1'b0;
      rom_state = '0;
      last_disc = '0;
      zero_branch = '0;
      search_over = 1'b0;
      cur_bit = '0;
      pass_open = 1'b0;
      kind_setting = 1'b0;
      last_prediction = '0;
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      running = 1'b1;

      write_search_kind(1'b0);
      test_special_cases();
      test_full_enumeration();
      test_alarm_search();
      test_family_target();
      test_empty_bus();
      write_search_kind(1'b1);
      test_request_noise(100);
      write_search_kind(1'b0);
      test_full_rate();

      quiesce();
      repeat (4) @(posedge clock);
      if (pending_results.size() != 0) begin
         report_error($sformatf("%0d predicted responses never arrived",
                                pending_results.size()));
      end
      $display("Summary: %0d requests, %0d responses checked, %0d search kind writes",
               requests_sent, responses_checked, kind_writes);
      $display("Summary: %0d ROM IDs found, %0d direction answers, %0d bus errors, %0d %s",
               status_seen[ST_FOUND], status_seen[ST_SEND_DIR], status_seen[ST_BUS_ERROR],
               status_seen[ST_FINISHED], "finished-search answers");
      if (error_count == 0) begin
         $display("one_wire_rom_search regression: pass");
      end else begin
         $display("one_wire_rom_search regression: fail");
      end
      $finish;
   end

endmodule
